FILE: design/p1_triangle_stiffness_matrix_defines.svh
// assertion macros for the triangle stiffness matrix block
`ifndef P1_TRIANGLE_STIFFNESS_MATRIX_DEFINES_SVH
`define P1_TRIANGLE_STIFFNESS_MATRIX_DEFINES_SVH
`ifndef SYNTH
`define TSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsm check failed");
`define TSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsm check failed");
`else
`define TSM_ASSERT_NOW(lbl, ante, cons)
`define TSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/tsm_pkg.sv
// shared types and constants of the triangle stiffness matrix block
`timescale 1ns / 1ps
`default_nettype none
package tsm_pkg;
  localparam int CW    = 24;
  localparam int EW    = CW + 1;
  localparam int PW    = 2 * EW;
  localparam int SW    = PW + 1;
  localparam int DW    = SW + 1;
  localparam int KW    = 32;
  localparam int QW    = KW + 1;
  localparam int NPAIR = 6;
  localparam int NVERT = 3;

  localparam int PAIR_I [NPAIR] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [NPAIR] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic                       degenerate;
    logic [SW-1:0]              det;
    logic [NPAIR-1:0][SW-1:0]   dot;
  } tsm_job_t;

  typedef struct packed {
    logic [NPAIR-1:0][KW-1:0]   k;
    logic                       degenerate;
    logic                       saturated;
  } tsm_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsm_qstat_t;
endpackage
`default_nettype wire

FILE: design/tsm_front.sv
// front end: edge vectors, products, doubled area and edge dot products
`timescale 1ns / 1ps
`default_nettype none
module tsm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tsm_pkg::CW-1:0]     in_vertex0_x,
  input  logic signed [tsm_pkg::CW-1:0]     in_vertex0_y,
  input  logic signed [tsm_pkg::CW-1:0]     in_vertex1_x,
  input  logic signed [tsm_pkg::CW-1:0]     in_vertex1_y,
  input  logic signed [tsm_pkg::CW-1:0]     in_vertex2_x,
  input  logic signed [tsm_pkg::CW-1:0]     in_vertex2_y,
  output logic                              job_valid,
  input  logic                              job_ready,
  output tsm_pkg::tsm_job_t                 job
);
  import tsm_pkg::*;

  logic adv;
  logic f1_valid_r, f2_valid_r, f3_valid_r;
  logic signed [EW-1:0] ex_r [NVERT];
  logic signed [EW-1:0] ey_r [NVERT];
  logic signed [EW-1:0] ex_nxt [NVERT];
  logic signed [EW-1:0] ey_nxt [NVERT];
  logic signed [PW-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic signed [PW-1:0] px_r [NPAIR];
  logic signed [PW-1:0] py_r [NPAIR];
  logic signed [PW-1:0] px_nxt [NPAIR];
  logic signed [PW-1:0] py_nxt [NPAIR];
  tsm_job_t job_r, job_nxt;

  assign adv       = !f3_valid_r || job_ready;
  assign in_stall  = !adv;
  assign job_valid = f3_valid_r;
  assign job       = job_r;

  // edges opposite each vertex
  always_comb begin
    ex_nxt[0] = EW'(in_vertex2_x) - EW'(in_vertex1_x);
    ey_nxt[0] = EW'(in_vertex2_y) - EW'(in_vertex1_y);
    ex_nxt[1] = EW'(in_vertex0_x) - EW'(in_vertex2_x);
    ey_nxt[1] = EW'(in_vertex0_y) - EW'(in_vertex2_y);
    ex_nxt[2] = EW'(in_vertex1_x) - EW'(in_vertex0_x);
    ey_nxt[2] = EW'(in_vertex1_y) - EW'(in_vertex0_y);
  end

  always_comb begin
    pa_nxt = PW'(ex_r[1]) * PW'(ey_r[2]);
    pb_nxt = PW'(ex_r[2]) * PW'(ey_r[1]);
    for (int n = 0; n < NPAIR; n++) begin
      px_nxt[n] = PW'(ex_r[PAIR_I[n]]) * PW'(ex_r[PAIR_J[n]]);
      py_nxt[n] = PW'(ey_r[PAIR_I[n]]) * PW'(ey_r[PAIR_J[n]]);
    end
  end

  always_comb begin
    job_nxt.degenerate = (pa_r == pb_r);
    job_nxt.det        = SW'(pa_r) - SW'(pb_r);
    for (int n = 0; n < NPAIR; n++) begin
      job_nxt.dot[n] = SW'(px_r[n]) + SW'(py_r[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      job_r <= job_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: design/tsm_queue.sv
// two-entry job queue between front end and divider back end
`timescale 1ns / 1ps
`default_nettype none
module tsm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tsm_pkg::tsm_job_t    push_data,
  input  logic                 pop,
  output tsm_pkg::tsm_job_t    pop_data,
  output tsm_pkg::tsm_qstat_t  stat
);
  import tsm_pkg::*;
  `include "p1_triangle_stiffness_matrix_defines.svh"

  localparam int QD   = 2;
  localparam int PTRW = $clog2(QD);
  localparam int CNTW = $clog2(QD + 1);

  tsm_job_t mem_r [QD];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNTW'(QD));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TSM_ASSERT_NOW(a_no_overflow, push, !stat.full || pop)
  `TSM_ASSERT_NOW(a_no_underflow, pop, !stat.empty)
  `TSM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNTW'(QD))
endmodule
`default_nettype wire

FILE: design/tsm_back.sv
// back end: magnitudes, pipelined restoring division, rounding and saturation
`timescale 1ns / 1ps
`default_nettype none
module tsm_back #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsm_pkg::tsm_job_t    job,
  input  tsm_pkg::tsm_qstat_t  qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsm_pkg::tsm_res_t    res
);
  import tsm_pkg::*;
  `include "p1_triangle_stiffness_matrix_defines.svh"

  localparam int NW = SW + OUT_FRAC_BITS + 1;

  logic adv;

  // magnitude stage
  logic                 b0_valid_r;
  logic                 b0_deg_r;
  logic [DW-1:0]        b0_den_r, b0_den_nxt;
  logic [SW-1:0]        b0_mag_r [NPAIR];
  logic [SW-1:0]        b0_mag_nxt [NPAIR];
  logic [NPAIR-1:0]     b0_neg_r, b0_neg_nxt;

  // divider stages, index 0 holds the initial remainder
  logic [QW:0]          st_valid_r;
  logic                 st_deg_r [QW+1];
  logic [DW-1:0]        st_den_r [QW+1];
  logic [NPAIR-1:0]     st_neg_r [QW+1];
  logic [NPAIR-1:0]     st_ovf_r [QW+1];
  logic [NPAIR-1:0]     st0_ovf_nxt;
  logic [DW-1:0]        st_rem_r   [QW+1][NPAIR];
  logic [DW-1:0]        st_rem_nxt [QW+1][NPAIR];
  logic [QW-1:0]        st_q_r     [QW+1][NPAIR];
  logic [QW-1:0]        st_q_nxt   [QW+1][NPAIR];

  // rounding stage
  logic                 rd_valid_r;
  logic                 rd_deg_r;
  logic [NPAIR-1:0]     rd_neg_r, rd_ovf_r;
  logic [QW-1:0]        rd_rnd_r   [NPAIR];
  logic [QW-1:0]        rd_rnd_nxt [NPAIR];

  logic                 out_valid_r;
  tsm_res_t             res_r, res_nxt;

  assign adv       = !out_valid_r || !out_stall;
  assign pop       = adv && !qstat.empty;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    logic signed [SW-1:0] sv;
    sv         = signed'(job.det);
    b0_den_nxt = {(sv[SW-1] ? SW'(-sv) : SW'(sv)), 1'b0};
    for (int n = 0; n < NPAIR; n++) begin
      sv            = signed'(job.dot[n]);
      b0_neg_nxt[n] = sv[SW-1];
      b0_mag_nxt[n] = sv[SW-1] ? SW'(-sv) : SW'(sv);
    end
  end

  always_comb begin
    logic [NW-1:0] num;
    logic [DW:0]   r2;
    logic [DW:0]   diff;
    logic          ge;
    for (int n = 0; n < NPAIR; n++) begin
      num               = {b0_mag_r[n], {(OUT_FRAC_BITS + 1){1'b0}}};
      st_rem_nxt[0][n]  = DW'(num[NW-1:QW]);
      st_q_nxt[0][n]    = num[QW-1:0];
      st0_ovf_nxt[n]    = (DW'(num[NW-1:QW]) >= b0_den_r);
    end
    for (int s = 0; s < QW; s++) begin
      for (int n = 0; n < NPAIR; n++) begin
        r2                   = {st_rem_r[s][n], st_q_r[s][n][QW-1]};
        diff                 = r2 - {1'b0, st_den_r[s]};
        ge                   = (r2 >= {1'b0, st_den_r[s]});
        st_rem_nxt[s+1][n]   = ge ? diff[DW-1:0] : r2[DW-1:0];
        st_q_nxt[s+1][n]     = {st_q_r[s][n][QW-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int n = 0; n < NPAIR; n++) begin
      rd_rnd_nxt[n] = {1'b0, st_q_r[QW][n][QW-1:1]} + QW'(st_q_r[QW][n][0]);
    end
  end

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] val;
    logic          clip;
    res_nxt = '0;
    for (int n = 0; n < NPAIR; n++) begin
      lim  = rd_neg_r[n] ? (QW'(1) << (KW - 1)) : ((QW'(1) << (KW - 1)) - QW'(1));
      clip = rd_ovf_r[n] || (rd_rnd_r[n] > lim);
      val  = clip ? lim : rd_rnd_r[n];
      if (!rd_deg_r) begin
        res_nxt.k[n]      = rd_neg_r[n] ? (~val[KW-1:0] + 1'b1) : val[KW-1:0];
        res_nxt.saturated = res_nxt.saturated | clip;
      end
    end
    res_nxt.degenerate = rd_deg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_valid_r  <= 1'b0;
      st_valid_r  <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b0_valid_r  <= !qstat.empty;
      st_valid_r  <= {st_valid_r[QW-1:0], b0_valid_r};
      rd_valid_r  <= st_valid_r[QW];
      out_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_deg_r    <= job.degenerate;
      b0_den_r    <= b0_den_nxt;
      b0_mag_r    <= b0_mag_nxt;
      b0_neg_r    <= b0_neg_nxt;
      st_deg_r[0] <= b0_deg_r;
      st_den_r[0] <= b0_den_r;
      st_neg_r[0] <= b0_neg_r;
      st_ovf_r[0] <= st0_ovf_nxt;
      for (int s = 0; s < QW; s++) begin
        st_deg_r[s+1] <= st_deg_r[s];
        st_den_r[s+1] <= st_den_r[s];
        st_neg_r[s+1] <= st_neg_r[s];
        st_ovf_r[s+1] <= st_ovf_r[s];
      end
      st_rem_r <= st_rem_nxt;
      st_q_r   <= st_q_nxt;
      rd_deg_r <= st_deg_r[QW];
      rd_neg_r <= st_neg_r[QW];
      rd_ovf_r <= st_ovf_r[QW];
      rd_rnd_r <= rd_rnd_nxt;
      res_r    <= res_nxt;
    end
  end

  `TSM_ASSERT_NOW(a_deg_zero, out_valid_r && res_r.degenerate, res_r.k == '0 && !res_r.saturated)
endmodule
`default_nettype wire

FILE: design/p1_triangle_stiffness_matrix.sv
// top level of the linear triangle element stiffness matrix block
// throughput: one item per cycle unless out_stall holds the pipeline; the restoring divider is a 33-stage pipeline
// a two-entry queue lets the front end keep accepting while the back end is stalled, until the queue is full
// reset: synchronous active-low rst_n clears all valid and queue state, no results pending
`timescale 1ns / 1ps
`default_nettype none
module p1_triangle_stiffness_matrix #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [tsm_pkg::CW-1:0]  in_vertex0_x,
  input  logic signed [tsm_pkg::CW-1:0]  in_vertex0_y,
  input  logic signed [tsm_pkg::CW-1:0]  in_vertex1_x,
  input  logic signed [tsm_pkg::CW-1:0]  in_vertex1_y,
  input  logic signed [tsm_pkg::CW-1:0]  in_vertex2_x,
  input  logic signed [tsm_pkg::CW-1:0]  in_vertex2_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [tsm_pkg::KW-1:0]  out_k_00,
  output logic signed [tsm_pkg::KW-1:0]  out_k_01,
  output logic signed [tsm_pkg::KW-1:0]  out_k_02,
  output logic signed [tsm_pkg::KW-1:0]  out_k_11,
  output logic signed [tsm_pkg::KW-1:0]  out_k_12,
  output logic signed [tsm_pkg::KW-1:0]  out_k_22,
  output logic                           out_degenerate,
  output logic                           out_saturated
);
  import tsm_pkg::*;

  logic       job_valid, job_ready, push, pop;
  tsm_job_t   job_in, job_out;
  tsm_qstat_t qstat;
  tsm_res_t   res;

  assign job_ready = !qstat.full || pop;
  assign push      = job_valid && job_ready;

  tsm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_vertex0_x (in_vertex0_x),
    .in_vertex0_y (in_vertex0_y),
    .in_vertex1_x (in_vertex1_x),
    .in_vertex1_y (in_vertex1_y),
    .in_vertex2_x (in_vertex2_x),
    .in_vertex2_y (in_vertex2_y),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job_in)
  );

  tsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job_in),
    .pop       (pop),
    .pop_data  (job_out),
    .stat      (qstat)
  );

  tsm_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_k_00       = res.k[0];
  assign out_k_01       = res.k[1];
  assign out_k_02       = res.k[2];
  assign out_k_11       = res.k[3];
  assign out_k_12       = res.k[4];
  assign out_k_22       = res.k[5];
  assign out_degenerate = res.degenerate;
  assign out_saturated  = res.saturated;
endmodule
`default_nettype wire
